// ----- rtl/core/sia_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the signed integer to decimal text block
// no dependencies

package sia_pkg;

    localparam int C_VALUE_W     = 32;
    localparam int C_NUM_DIGITS  = 10;
    localparam int C_BCD_W       = 4 * C_NUM_DIGITS;
    localparam int C_CNT_W       = 5;
    localparam int C_POS_W       = 4;

    localparam logic [7:0] C_ASCII_MINUS = 8'h2D;
    localparam logic [7:0] C_ASCII_ZERO  = 8'h30;
    localparam logic [3:0] C_BCD_FIVE    = 4'd5;
    localparam logic [3:0] C_BCD_ADJ     = 4'd3;
    localparam logic [C_CNT_W-1:0] C_LAST_SHIFT = C_CNT_W'(C_VALUE_W - 1);

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input value, take magnitude
        logic shift;       // one double-dabble step
        logic prep;        // size the text and set up emission
        logic step;        // push one character into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a character this cycle
        logic cur_last;    // the character at the pointer ends the text
    } t_dp_stat;

endpackage

// ----- rtl/core/sia_datapath.sv -----
`timescale 1ns / 1ps
// datapath: magnitude shift register, bcd digit register, emission pointer
// and output word register; depends on sia_pkg

module sia_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [sia_pkg::C_VALUE_W-1:0] i_value,
    input  sia_pkg::t_dp_cmd                i_cmd,
    output sia_pkg::t_dp_stat               o_stat,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [7:0]                      o_ascii_char,
    output logic                            o_is_last,
    output logic [3:0]                      o_char_count
);
    import sia_pkg::*;

    logic [C_VALUE_W-1:0] r_mag;
    logic [C_BCD_W-1:0]   r_bcd;
    logic                 r_neg;
    logic                 r_sign_pend;
    logic [C_POS_W-1:0]   r_idx;
    logic [3:0]           r_total;

    logic                 r_out_valid;
    logic [7:0]           r_char;
    logic                 r_last;
    logic [3:0]           r_count;

    logic [C_BCD_W-1:0]   w_bcd_adj;
    logic [3:0]           w_ndig;
    logic [3:0]           w_cur_digit;
    logic [7:0]           w_cur_char;
    logic                 w_cur_last;
    logic [C_VALUE_W-1:0] w_raw;

    assign w_raw = i_value;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < C_NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= C_BCD_FIVE) begin
                w_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + C_BCD_ADJ;
            end else begin
                w_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // number of significant digits, at least one
    always_comb begin
        w_ndig = 4'd1;
        for (int i = 1; i < C_NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                w_ndig = 4'(i + 1);
            end
        end
    end

    always_comb begin
        w_cur_digit = 4'd0;
        for (int i = 0; i < C_NUM_DIGITS; i++) begin
            if (r_idx == C_POS_W'(i)) begin
                w_cur_digit = r_bcd[4*i +: 4];
            end
        end
    end

    assign w_cur_char = r_sign_pend ? C_ASCII_MINUS : (C_ASCII_ZERO + {4'd0, w_cur_digit});
    assign w_cur_last = !r_sign_pend && (r_idx == '0);

    assign o_stat.out_free = !r_out_valid || !i_stall;
    assign o_stat.cur_last = w_cur_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= w_raw[C_VALUE_W-1];
            r_mag <= w_raw[C_VALUE_W-1] ? (~w_raw + 1'b1) : w_raw;
            r_bcd <= '0;
        end else if (i_cmd.shift) begin
            {r_bcd, r_mag} <= {w_bcd_adj[C_BCD_W-2:0], r_mag, 1'b0};
        end
        if (i_cmd.prep) begin
            r_idx   <= w_ndig - 4'd1;
            r_total <= w_ndig + {3'd0, r_neg};
        end else if (i_cmd.step && !r_sign_pend) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.step) begin
            r_char  <= w_cur_char;
            r_last  <= w_cur_last;
            r_count <= w_cur_last ? r_total : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sign_pend <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.prep) begin
                r_sign_pend <= r_neg;
            end else if (i_cmd.step) begin
                r_sign_pend <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_char;
    assign o_is_last    = r_last;
    assign o_char_count = r_count;

    a_count_on_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_count != 4'd0))
        else $error("last word carries no count");
    a_no_count_inner : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_count == 4'd0))
        else $error("inner word carries a count");
    a_step_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_out_valid || !i_stall))
        else $error("output word overwritten while stalled");

endmodule

// ----- rtl/core/sia_ctrl.sv -----
`timescale 1ns / 1ps
// controller: sequences load, 32 conversion shifts, sizing and character
// emission; depends on sia_pkg

module sia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output sia_pkg::t_dp_cmd  o_cmd,
    input  sia_pkg::t_dp_stat i_stat
);
    import sia_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_PREP,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [C_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == C_LAST_SHIFT) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.cur_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_CONV && r_cnt == '0))
        else $error("accepted word did not start conversion");
    a_conv_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_cnt == C_LAST_SHIFT) |=> (r_state == S_PREP))
        else $error("conversion did not end after the last shift");
    a_last_returns : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_stat.cur_last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after last word");

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// Converts one signed 32-bit value into its decimal text, one character per output
// word: an optional '-', then the digits most significant first without leading zeros
// ("0" for zero, "-2147483648" for the most negative value). The last word has
// o_is_last set and o_char_count holding the total length; inner words carry a zero
// count. A value goes through a load, 32 bit-serial binary to bcd shifts, a sizing step
// and then emission of one character per cycle (1 to 11) while the output is not stalled.
// The input is stalled from acceptance until the last character enters the output
// register, which may still wait on the consumer while the next value converts.
// depends on sia_pkg, sia_ctrl and sia_datapath

module signed_int_to_decimal_ascii (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [sia_pkg::C_VALUE_W-1:0] i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [7:0]                           o_ascii_char,
    output logic                                 o_is_last,
    output logic [3:0]                           o_char_count
);
    import sia_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    sia_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_ascii_char (o_ascii_char),
        .o_is_last    (o_is_last),
        .o_char_count (o_char_count)
    );

endmodule

// ----- tb/signed_int_to_decimal_ascii_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for signed_int_to_decimal_ascii: drives signed 32-bit values and
// checks every text word against a local prediction of the decimal characters
// depends on sia_pkg and the signed_int_to_decimal_ascii rtl

module signed_int_to_decimal_ascii_test;

    import sia_pkg::*;

    localparam int          RESET_CYCLES   = 12;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          DRAIN_CYCLES   = 80;
    localparam int          RX_HOLD_CYCLES = 250;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [31:0] RADIX          = 32'd10;

    localparam logic [31:0] POW10 [0:C_NUM_DIGITS-1] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
        32'd10000000, 32'd100000000, 32'd1000000000
    };

    typedef struct {
        logic [7:0]                   ch;
        logic                         last;
        logic [3:0]                   count;
        logic signed [C_VALUE_W-1:0]  source;
    } t_text_char;

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic signed [C_VALUE_W-1:0] i_value = '0;
    logic                        i_stall = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [7:0]                  o_ascii_char;
    logic                        o_is_last;
    logic [3:0]                  o_char_count;

    t_text_char  pending_chars [$];
    int unsigned text_errors  = 0;
    logic        rx_idle_en   = 1'b0;
    int unsigned rx_hold_reqs = 0;

    signed_int_to_decimal_ascii dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_is_last    (o_is_last),
        .o_char_count (o_char_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected characters of one value: optional sign, then digits most significant first
    task automatic predict_text(input logic signed [C_VALUE_W-1:0] value);
        logic        neg;
        logic [31:0] mag;
        logic [3:0]  digits [0:C_NUM_DIGITS-1];
        int          n;
        int          total;
        t_text_char  c;
        neg = value[C_VALUE_W-1];
        // two's complement magnitude, so the most negative value stays 2147483648
        mag = neg ? (~value + 32'd1) : value;
        n = 0;
        do begin
            digits[n] = 4'(mag % RADIX);
            mag = mag / RADIX;
            n++;
        end while (mag != 0 && n < C_NUM_DIGITS);
        total = n + (neg ? 1 : 0);
        c.source = value;
        if (neg) begin
            c.ch    = C_ASCII_MINUS;
            c.last  = 1'b0;
            c.count = 4'd0;
            pending_chars.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--) begin
            c.ch    = C_ASCII_ZERO + 8'(digits[i]);
            c.last  = (i == 0);
            c.count = (i == 0) ? 4'(total) : 4'd0;
            pending_chars.push_back(c);
        end
    endtask

    // holds the word until the block takes it; valid is left high for the caller
    task automatic send_value(input logic signed [C_VALUE_W-1:0] value);
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        predict_text(value);
    endtask

    task automatic pause_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // mostly picks a digit count first so short and long texts are equally common
    function automatic logic signed [C_VALUE_W-1:0] random_value();
        int unsigned kind;
        int unsigned digits;
        logic [31:0] lo;
        logic [31:0] hi;
        logic signed [C_VALUE_W-1:0] v;
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
            v = $urandom;
        end else if (kind == 3) begin
            v = {1'b1, {(C_VALUE_W-1){1'b0}}};
        end else begin
            digits = $urandom_range(1, C_NUM_DIGITS);
            lo = (digits == 1) ? 32'd0 : POW10[digits-1];
            hi = (digits == C_NUM_DIGITS) ? 32'h7FFF_FFFF : POW10[digits] - 32'd1;
            v = $urandom_range(hi, lo);
            if ($urandom_range(0, 1) == 1) v = -v;
        end
        return v;
    endfunction

    task automatic test_directed_values();
        logic signed [C_VALUE_W-1:0] picks [$];
        picks = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
            32'sd100, -32'sd100, 32'sh7FFF_FFFF, 32'sh8000_0001, 32'sh8000_0000,
            32'sd999999999, 32'sd1000000000, -32'sd999999999, -32'sd1000000000,
            32'sd1234567890, -32'sd1234567890, 32'sh5555_5555, 32'shAAAA_AAAA,
            32'sh0000_FFFF
        };
        foreach (picks[i]) send_value(picks[i]);
    endtask

    task automatic test_random_values(input int count);
        repeat (count) begin
            send_value(random_value());
            if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 14));
        end
    endtask

    // receiver holds off while words keep coming, so the input side backs up
    task automatic test_output_backpressure();
        rx_hold_reqs <= rx_hold_reqs + 1;
        repeat (10) send_value(random_value());
    endtask

    task automatic test_pause_until_drained();
        repeat (3) send_value(random_value());
        wait_for_drain();
        repeat (3) send_value(random_value());
        wait_for_drain();
        send_value(32'sh8000_0000);
    endtask

    task automatic test_back_to_back(input int count);
        repeat (count) send_value(random_value());
    endtask

    initial begin : rx_stall_gen
        int unsigned served;
        int unsigned hold_left;
        int unsigned burst_left;
        served = 0;
        hold_left = 0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_reqs != served) begin
                served = rx_hold_reqs;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst_left != 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 14) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_text
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                if (text_errors < MAX_REPORTS)
                    $display("unexpected word: char %h last %b count %0d",
                             o_ascii_char, o_is_last, o_char_count);
                text_errors++;
            end else begin
                want = pending_chars.pop_front();
                if (o_ascii_char !== want.ch || o_is_last !== want.last ||
                    o_char_count !== want.count) begin
                    if (text_errors < MAX_REPORTS)
                        $display("mismatch for %0d: expected %h/%b/%0d, got %h/%b/%0d",
                                 want.source, want.ch, want.last, want.count,
                                 o_ascii_char, o_is_last, o_char_count);
                    text_errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_values();
        wait_for_drain();

        rx_idle_en <= 1'b1;
        test_random_values(140);
        test_output_backpressure();
        test_pause_until_drained();

        // closing stretch runs at full rate on both sides
        rx_idle_en <= 1'b0;
        test_back_to_back(40);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (text_errors == 0 && pending_chars.size() == 0) begin
            $display("signed_int_to_decimal_ascii test passed");
        end else begin
            $display("signed_int_to_decimal_ascii test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sia_pkg.sv
rtl/core/sia_datapath.sv
rtl/core/sia_ctrl.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_test.sv
